>>> hw/rtl/ctc_pkg.sv
// Shared types and constants for the columnar transposition cipher.
// No dependencies; used by ctc_ctrl, ctc_dp and columnar_transposition_cipher.
`default_nettype none

package ctc_pkg;

    localparam logic [2:0] NCOLS     = 3'd5;
    localparam logic [2:0] LAST_COL  = 3'd4;
    localparam logic [7:0] PAD_CHAR  = 8'h58;   // 'X'
    localparam logic [7:0] DIGIT0    = 8'h30;   // '0'
    localparam logic [7:0] DIGIT_MAX = 8'h34;   // '4'

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PREP,
        ST_ISSUE,
        ST_SHOW
    } ctc_state_t;

    typedef enum logic {
        RES_MEM,
        RES_CONST
    } ctc_kind_t;

    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic prep;     // work out run geometry
        logic issue;    // form the next result word
        logic advance;  // result word taken, step the walk
        logic finish;   // last result taken, clear the grid state
    } ctc_cmd_t;

    typedef struct packed {
        logic eom;      // shown result is the last of the run
    } ctc_status_t;

    // Column read in each output slot when encrypting
    function automatic logic [2:0] key_col(input logic [2:0] slot);
        logic [2:0] col;
        case (slot)
            3'd0:    col = 3'd2;
            3'd1:    col = 3'd0;
            3'd2:    col = 3'd4;
            3'd3:    col = 3'd3;
            3'd4:    col = 3'd1;
            default: col = 3'd0;
        endcase
        return col;
    endfunction

    // Ciphertext block holding each plaintext column
    function automatic logic [2:0] col_slot(input logic [2:0] col);
        logic [2:0] slot;
        case (col)
            3'd0:    slot = 3'd1;
            3'd1:    slot = 3'd4;
            3'd2:    slot = 3'd0;
            3'd3:    slot = 3'd3;
            3'd4:    slot = 3'd2;
            default: slot = 3'd0;
        endcase
        return slot;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ctc_ctrl.sv
// Sequencing state machine for the columnar transposition cipher.
// Depends on ctc_pkg; drives the command struct of ctc_dp.
`default_nettype none

module ctc_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    input  wire                  s_tlast,
    input  wire                  m_tready,
    input  ctc_pkg::ctc_status_t status,
    output logic                 s_tready,
    output logic                 m_tvalid,
    output ctc_pkg::ctc_cmd_t    cmd
);

    ctc_pkg::ctc_state_t state_reg;
    ctc_pkg::ctc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctc_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ctc_pkg::ST_LOAD:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ctc_pkg::ST_PREP;
                end
            end
            ctc_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ctc_pkg::ST_ISSUE;
            end
            ctc_pkg::ST_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = ctc_pkg::ST_SHOW;
            end
            ctc_pkg::ST_SHOW:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cmd.advance = 1'b1;
                    cmd.finish  = status.eom;
                    state_next  = status.eom ? ctc_pkg::ST_LOAD : ctc_pkg::ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ctc_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ctc_dp.sv
// Datapath of the columnar transposition cipher: grid memory, counters, address walk.
// Depends on ctc_pkg; commanded by ctc_ctrl.
`default_nettype none

module ctc_dp #(
    parameter int ROWS = 8
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ctc_pkg::ctc_cmd_t    cmd,
    input  wire  [7:0]           in_byte,
    input  wire                  in_last,
    input  wire                  cfg_we,
    input  wire                  cfg_wdata,
    output ctc_pkg::ctc_status_t status,
    output logic [7:0]           out_byte,
    output logic                 out_eom,
    output logic                 out_ovf,
    output logic                 out_bad
);

    localparam int CAP = 5 * ROWS;
    localparam int AW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);
    localparam int RW  = $clog2(ROWS + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAP);

    logic [7:0] grid_mem [CAP];

    logic          mode_reg;
    logic          dec_reg;
    logic [7:0]    digit_reg;
    logic [CW-1:0] count_reg;
    logic [2:0]    col_reg;
    logic [RW-1:0] row_reg;
    logic          ovf_reg;

    logic [RW-1:0] rc_reg;
    logic [2:0]    pad_reg;
    logic [CW-1:0] len_reg;
    logic          err_reg;
    logic          single_reg;
    logic [AW-1:0] top_reg;

    logic [2:0]    slot_reg;
    logic [RW-1:0] erow_reg;
    logic [AW-1:0] base_reg;
    logic          digit_phase_reg;
    logic [CW-1:0] idx_reg;
    logic [RW-1:0] drow_reg;
    logic [2:0]    dcol_reg;

    ctc_pkg::ctc_kind_t kind_reg;
    logic [7:0]    const_reg;
    logic [7:0]    rd_reg;
    logic          eom_reg;
    logic          bad_reg;

    logic          has_room;
    logic          dec_final;
    logic          store_en;
    logic          col_nz;
    logic [RW-1:0] rc_calc;
    logic [RW-1:0] rcm1;
    logic [CW-1:0] top_calc;
    logic [2:0]    enc_pad;
    logic          dec_err;
    logic [CW-1:0] dec_len;
    logic [AW-1:0] enc_addr;
    logic [CW-1:0] slot_mul;
    logic [RW-1:0] dec_off;
    logic [CW-1:0] dec_sum;
    logic [AW-1:0] rd_addr;
    logic          enc_is_pad;

    assign has_room  = count_reg < CAP_C;
    assign dec_final = in_last && mode_reg;
    assign store_en  = cmd.accept && has_room && !dec_final;

    // Run geometry, valid in the prep cycle
    assign col_nz   = col_reg != 3'd0;
    assign rc_calc  = dec_reg ? row_reg : row_reg + RW'(col_nz);
    assign rcm1     = rc_calc - RW'(1);
    assign top_calc = (CW'(rcm1) << 2) + CW'(rcm1);
    assign enc_pad  = col_nz ? ctc_pkg::NCOLS - col_reg : 3'd0;
    assign dec_err  = col_nz || (digit_reg < ctc_pkg::DIGIT0)
                      || (digit_reg > ctc_pkg::DIGIT_MAX)
                      || ((row_reg == '0) && (digit_reg != ctc_pkg::DIGIT0));
    assign dec_len  = count_reg - CW'(digit_reg[2:0]);

    // Read addresses for both walks
    assign enc_addr   = base_reg + AW'(ctc_pkg::key_col(slot_reg));
    assign enc_is_pad = CW'(enc_addr) >= count_reg;
    assign slot_mul   = CW'(ctc_pkg::col_slot(dcol_reg)) * CW'(rc_reg);
    assign dec_off    = rc_reg - RW'(1) - drow_reg;
    assign dec_sum    = slot_mul + CW'(dec_off);
    assign rd_addr    = dec_reg ? dec_sum[AW-1:0] : enc_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // Load counters and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            col_reg   <= 3'd0;
            row_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.finish)
        begin
            count_reg <= '0;
            col_reg   <= 3'd0;
            row_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.accept && !dec_final)
        begin
            if (has_room)
            begin
                count_reg <= count_reg + CW'(1);
                if (col_reg == ctc_pkg::LAST_COL)
                begin
                    col_reg <= 3'd0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + 3'd1;
                end
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            grid_mem[count_reg[AW-1:0]] <= in_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_reg <= grid_mem[rd_addr];
        end
    end

    // Sample mode and pad digit with the final word
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_last)
        begin
            dec_reg   <= mode_reg;
            digit_reg <= in_byte;
        end
    end

    // Latch geometry (the walks are started on the same prep command)
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            rc_reg     <= rc_calc;
            pad_reg    <= dec_reg ? digit_reg[2:0] : enc_pad;
            len_reg    <= dec_len;
            err_reg    <= dec_reg && dec_err;
            single_reg <= dec_reg && (dec_err || (dec_len == '0));
            top_reg    <= top_calc[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            slot_reg        <= 3'd0;
            erow_reg        <= rcm1;
            base_reg        <= top_calc[AW-1:0];
            digit_phase_reg <= 1'b0;
            idx_reg         <= '0;
            drow_reg        <= '0;
            dcol_reg        <= 3'd0;
        end
        else if (cmd.advance)
        begin
            if (dec_reg)
            begin
                idx_reg <= idx_reg + CW'(1);
                if (dcol_reg == ctc_pkg::LAST_COL)
                begin
                    dcol_reg <= 3'd0;
                    drow_reg <= drow_reg + RW'(1);
                end
                else
                begin
                    dcol_reg <= dcol_reg + 3'd1;
                end
            end
            else if (erow_reg == '0)
            begin
                if (slot_reg == ctc_pkg::LAST_COL)
                begin
                    digit_phase_reg <= 1'b1;
                end
                else
                begin
                    slot_reg <= slot_reg + 3'd1;
                    erow_reg <= rc_reg - RW'(1);
                    base_reg <= top_reg;
                end
            end
            else
            begin
                erow_reg <= erow_reg - RW'(1);
                base_reg <= base_reg - AW'(ctc_pkg::NCOLS);
            end
        end
    end

    // Form the result word
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            if (single_reg)
            begin
                kind_reg  <= ctc_pkg::RES_CONST;
                const_reg <= 8'h00;
                eom_reg   <= 1'b1;
                bad_reg   <= err_reg;
            end
            else if (dec_reg)
            begin
                kind_reg  <= ctc_pkg::RES_MEM;
                const_reg <= 8'h00;
                eom_reg   <= idx_reg == len_reg - CW'(1);
                bad_reg   <= 1'b0;
            end
            else if (digit_phase_reg)
            begin
                kind_reg  <= ctc_pkg::RES_CONST;
                const_reg <= ctc_pkg::DIGIT0 + 8'(pad_reg);
                eom_reg   <= 1'b1;
                bad_reg   <= 1'b0;
            end
            else
            begin
                kind_reg  <= enc_is_pad ? ctc_pkg::RES_CONST : ctc_pkg::RES_MEM;
                const_reg <= ctc_pkg::PAD_CHAR;
                eom_reg   <= 1'b0;
                bad_reg   <= 1'b0;
            end
        end
    end

    assign out_byte   = (kind_reg == ctc_pkg::RES_MEM) ? rd_reg : const_reg;
    assign out_eom    = eom_reg;
    assign out_ovf    = ovf_reg;
    assign out_bad    = bad_reg;
    assign status.eom = eom_reg;

`ifndef SYNTH
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("stored count beyond grid capacity");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= ctc_pkg::LAST_COL)
        else $error("load column out of range");

    a_count_geom: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == (CW'(row_reg) * CW'(ctc_pkg::NCOLS)) + CW'(col_reg))
        else $error("count disagrees with row and column");

    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (count_reg == '0) && !ovf_reg)
        else $error("grid state not cleared after run");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/columnar_transposition_cipher.sv
// Top level of the five-column transposition cipher (key 2,0,4,3,1).
// Depends on ctc_pkg, ctc_ctrl and ctc_dp.
//
// Usage:
//   Input words arrive on the s_ channel, one character each; s_tlast marks
//   the last character of a message. Characters load row-wise into a grid of
//   five columns and ROWS rows, one word per cycle. Nothing comes out until
//   the last character. cfg_we/cfg_wdata set the mode (0 encrypt, 1 decrypt);
//   write it only while the block is idle. The mode is sampled with the last
//   character. Encrypt pads with 'X', emits columns in key order bottom row
//   first, then the pad digit. Decrypt takes the last character as the pad
//   digit and emits the plaintext; a malformed ciphertext gives one word with
//   bad_cipher set. Characters past capacity are dropped and flagged.
// Timing:
//   The first result is valid once the last character is taken, the run
//   geometry is worked out (prep state) and the grid memory is read (issue
//   state); each further result passes through the issue state again after
//   the previous one is taken, so a new result word is not formed until the
//   last one is taken. s_tready is low from the last character until the
//   final result of the run is taken.
// Reset clears the mode, the character count and the overflow flag; the grid
// memory is not cleared, but unwritten locations never reach m_tdata. A stall
// on m_tready holds the current result word stable and halts the walk.
`default_nettype none

module columnar_transposition_cipher #(
    parameter int ROWS = 8
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,    // [7:0] text_byte
    input  wire        s_tlast,    // is_final
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,    // end_of_message
    output logic [1:0] m_tuser,    // [0] overflowed, [1] bad_cipher
    input  wire        cfg_we,
    input  wire        cfg_wdata   // mode
);

    ctc_pkg::ctc_cmd_t    cmd;
    ctc_pkg::ctc_status_t status;
    logic                 ovf;
    logic                 bad;

    ctc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    ctc_dp #(
        .ROWS (ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .out_byte  (m_tdata),
        .out_eom   (m_tlast),
        .out_ovf   (ovf),
        .out_bad   (bad)
    );

    // Pack the flags onto tuser, overflow in the low bit
    assign m_tuser = {bad, ovf};

endmodule

`default_nettype wire
